### hdl/assert_macros.svh
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pcc_pkg.sv
// Package: widths, constants and types of the particle code classifier.
package pcc_pkg;

  localparam int unsigned CODE_W  = 32;
  localparam int unsigned UNEXC_W = 17;
  localparam int unsigned NSTAGES = 10;

  // Exact codes tested on the signed value
  localparam logic signed [CODE_W-1:0] GLUON_CODE     = 32'sd21;
  localparam logic signed [CODE_W-1:0] GLUON_ALT_CODE = 32'sd9;
  localparam logic signed [CODE_W-1:0] PHOTON_CODE    = 32'sd22;
  localparam logic signed [CODE_W-1:0] ZBOSON_CODE    = 32'sd23;

  // Reciprocal of 100000, scaled by 2^48 (floor)
  localparam logic [31:0]         MAG_RECIP = 32'd2814749767;
  localparam logic [UNEXC_W-1:0]  UNEXC_MOD = 17'd100000;
  // Reciprocal of 100, scaled by 2^24 (floor)
  localparam logic [17:0]         RECIP100  = 18'd167772;
  localparam logic [6:0]          HUNDRED   = 7'd100;
  // x / 10 == (x * 205) >> 11 for x < 1029
  localparam logic [7:0]          DIV10_MUL = 8'd205;
  localparam logic [3:0]          TEN       = 4'd10;

  localparam logic [UNEXC_W-1:0]  DIQ_LO    = 17'd1103;
  localparam logic [UNEXC_W-1:0]  DIQ_HI    = 17'd8803;
  localparam logic [UNEXC_W-1:0]  PI0_CODE  = 17'd111;

  typedef struct packed {
    logic gluon;
    logic photon;
    logic zboson;
  } pcc_boson_t;

  typedef struct packed {
    logic gluon;
    logic photon;
    logic zboson;
    logic quark;
    logic diquark;
    logic light_qdq;
    logic charm_qdq;
    logic bottom_qdq;
    logic charm_meson;
    logic bottom_meson;
    logic neutral_pion;
  } pcc_flags_t;

endpackage

### hdl/pcc_in_if.sv
// Input channel: one signed particle code per transaction.
interface pcc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcc_pkg::CODE_W-1:0]   particle_code;

  modport source (output valid, output particle_code, input ready);
  modport sink   (input valid, input particle_code, output ready);
endinterface

### hdl/pcc_out_if.sv
// Output channel: eleven class flags per transaction.
interface pcc_out_if;
  logic valid;
  logic ready;
  logic is_gluon;
  logic is_photon;
  logic is_zboson;
  logic is_quark;
  logic is_diquark;
  logic is_light_quark_or_diquark;
  logic is_charm_qdq;
  logic is_bottom_qdq;
  logic is_charm_meson;
  logic is_bottom_meson;
  logic is_neutral_pion;

  modport source (output valid, input ready,
                  output is_gluon, is_photon, is_zboson, is_quark, is_diquark,
                  output is_light_quark_or_diquark, is_charm_qdq,
                  output is_bottom_qdq, is_charm_meson,
                  output is_bottom_meson, is_neutral_pion);
  modport sink   (input valid, output ready,
                  input is_gluon, is_photon, is_zboson, is_quark, is_diquark,
                  input is_light_quark_or_diquark, is_charm_qdq,
                  input is_bottom_qdq, is_charm_meson,
                  input is_bottom_meson, is_neutral_pion);
endinterface

### hdl/particle_code_classifier.sv
// Top level: pipelined PDG particle code classifier.
//
// Usage:
//   in_i  carries one signed 32-bit particle code per transaction.
//   out_o carries the eleven class flags for that code, in input order.
//   Both channels use valid/ready; a transaction completes when both are high.
// Throughput: one code per cycle while the output is not stalled. The ten
//   register stages run the digit extraction: magnitude, reciprocal
//   multiply by 1/100000, remainder and correction, reciprocal multiply by
//   1/100, remainder and correction, two divide-by-ten steps, then the flag
//   logic into the output register.
// Stall: the whole pipeline holds while out_o.valid is high and out_o.ready
//   is low; in_i.ready is low exactly then, so nothing is dropped or repeated.
// Reset: rst_ni (async, active low) clears all stage valid bits; the block
//   holds no other state and is ready for a new code right after reset.
// Gluon, photon and Z0 compare the signed code; all other flags use
//   |code| mod 100000 (or mod 10000 for mesons, the low four digits of it).

`include "assert_macros.svh"

module particle_code_classifier (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcc_in_if.sink         in_i,
  pcc_out_if.source      out_o
);

  localparam int unsigned LAST = pcc_pkg::NSTAGES - 1;

  // Stage valid bits; [LAST] is the output register
  logic [pcc_pkg::NSTAGES-1:0] valid_q;
  logic                        adv;

  // Boson flags travel alongside the digit pipeline (stages 1..9)
  pcc_pkg::pcc_boson_t bos_q [LAST];
  pcc_pkg::pcc_boson_t bos_d;

  // Stage 1: magnitude
  logic [31:0]  mag1_d, mag1_q;
  // Stage 2: quotient estimate of mag / 100000
  logic [63:0]  prod2;
  logic [15:0]  qe2_q;
  logic [31:0]  mag2_q;
  // Stage 3: raw remainder, below 200000
  logic [32:0]  prod3;
  logic [32:0]  diff3;
  logic [17:0]  r3_q;
  // Stage 4: unexcited code u
  logic [pcc_pkg::UNEXC_W-1:0] u4_d, u4_q;
  // Stage 5: quotient estimate of u / 100
  logic [34:0]  prod5;
  logic [9:0]   qe5_q;
  logic [pcc_pkg::UNEXC_W-1:0] u5_q;
  // Stage 6: raw remainder, below 200
  logic [16:0]  diff6;
  logic [7:0]   r6_q;
  logic [9:0]   qe6_q;
  logic [pcc_pkg::UNEXC_W-1:0] u6_q;
  // Stage 7: corrected u / 100 and u % 100
  logic [9:0]   q7_d, q7_q;
  logic [6:0]   rr7_d, rr7_q;
  logic [pcc_pkg::UNEXC_W-1:0] u7_q;
  // Stage 8: tens digit and u / 1000
  logic [14:0]  prod8a;
  logic [17:0]  prod8b;
  logic [3:0]   tens8_q;
  logic [6:0]   t8_q;
  logic [6:0]   rr8_q;
  logic [9:0]   q8_q;
  logic [pcc_pkg::UNEXC_W-1:0] u8_q;
  // Stage 9: units, hundreds digits and u / 10000
  logic [6:0]   units9_full;
  logic [9:0]   hu9_full;
  logic [14:0]  prod9;
  logic [3:0]   units9_q, hu9_q, td9_q, tens9_q;
  logic [6:0]   t9_q;
  logic [pcc_pkg::UNEXC_W-1:0] u9_q;
  // Stage 10: flags
  logic [6:0]   d3_full;
  logic [3:0]   d3;
  logic         dq;
  pcc_pkg::pcc_flags_t flags_d, flags_q;

  assign adv        = !valid_q[LAST] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[pcc_pkg::NSTAGES-2:0], in_i.valid};
    end
  end

  // Stage 1 logic
  always_comb begin
    mag1_d = in_i.particle_code[pcc_pkg::CODE_W-1]
           ? (~in_i.particle_code + 32'd1) : in_i.particle_code;
    bos_d.gluon  = (in_i.particle_code == pcc_pkg::GLUON_CODE) ||
                   (in_i.particle_code == pcc_pkg::GLUON_ALT_CODE);
    bos_d.photon = (in_i.particle_code == pcc_pkg::PHOTON_CODE);
    bos_d.zboson = (in_i.particle_code == pcc_pkg::ZBOSON_CODE);
  end

  // Stages 2..9 combinational pieces
  always_comb begin
    prod2 = 64'(mag1_q) * 64'(pcc_pkg::MAG_RECIP);

    prod3 = 33'(qe2_q) * 33'(pcc_pkg::UNEXC_MOD);
    diff3 = {1'b0, mag2_q} - prod3;

    u4_d = (r3_q >= 18'(pcc_pkg::UNEXC_MOD))
         ? 17'(r3_q - 18'(pcc_pkg::UNEXC_MOD)) : r3_q[16:0];

    prod5 = 35'(u4_q) * 35'(pcc_pkg::RECIP100);

    diff6 = u5_q - 17'(qe5_q) * 17'(pcc_pkg::HUNDRED);

    if (r6_q >= 8'(pcc_pkg::HUNDRED)) begin
      q7_d  = qe6_q + 10'd1;
      rr7_d = 7'(r6_q - 8'(pcc_pkg::HUNDRED));
    end else begin
      q7_d  = qe6_q;
      rr7_d = r6_q[6:0];
    end

    prod8a = 15'(rr7_q) * 15'(pcc_pkg::DIV10_MUL);
    prod8b = 18'(q7_q) * 18'(pcc_pkg::DIV10_MUL);

    units9_full = rr8_q - 7'(tens8_q) * 7'(pcc_pkg::TEN);
    hu9_full    = q8_q - 10'(t8_q) * 10'(pcc_pkg::TEN);
    prod9       = 15'(t8_q) * 15'(pcc_pkg::DIV10_MUL);
  end

  // Stage 10: digit tests. For a diquark u <= 8803, so u / 1000 is the
  // thousands digit itself.
  always_comb begin
    d3_full = t9_q - 7'(td9_q) * 7'(pcc_pkg::TEN);
    d3      = d3_full[3:0];
    dq      = (u9_q >= pcc_pkg::DIQ_LO) && (u9_q <= pcc_pkg::DIQ_HI) && (tens9_q == 4'd0);

    flags_d.gluon        = bos_q[LAST-1].gluon;
    flags_d.photon       = bos_q[LAST-1].photon;
    flags_d.zboson       = bos_q[LAST-1].zboson;
    flags_d.quark        = (u9_q >= 17'd1) && (u9_q <= 17'd8);
    flags_d.diquark      = dq;
    flags_d.light_qdq    = ((u9_q >= 17'd1) && (u9_q <= 17'd3)) ||
                           (dq && (((t9_q >= 7'd1) && (t9_q <= 7'd3)) ||
                                   ((hu9_q >= 4'd1) && (hu9_q <= 4'd3))));
    flags_d.charm_qdq    = (u9_q == 17'd4) || (dq && ((t9_q == 7'd4) || (hu9_q == 4'd4)));
    flags_d.bottom_qdq   = (u9_q == 17'd5) || (dq && ((t9_q == 7'd5) || (hu9_q == 4'd5)));
    flags_d.charm_meson  = (d3 == 4'd0) && (hu9_q == 4'd4) &&
                           (tens9_q >= 4'd1) && (tens9_q <= 4'd3) &&
                           ((units9_q == 4'd1) || (units9_q == 4'd3) || (units9_q == 4'd5));
    flags_d.bottom_meson = (d3 == 4'd0) && (hu9_q == 4'd5) &&
                           (tens9_q >= 4'd1) && (tens9_q <= 4'd4) &&
                           ((units9_q == 4'd1) || (units9_q == 4'd3) || (units9_q == 4'd5));
    flags_d.neutral_pion = (u9_q == pcc_pkg::PI0_CODE);
  end

  // Payload registers: no reset, move only when the pipeline advances
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_q   <= mag1_d;
      bos_q[0] <= bos_d;
      for (int i = 1; i < LAST; i++) begin
        bos_q[i] <= bos_q[i-1];
      end

      qe2_q    <= prod2[63:48];
      mag2_q   <= mag1_q;

      r3_q     <= diff3[17:0];

      u4_q     <= u4_d;

      qe5_q    <= prod5[33:24];
      u5_q     <= u4_q;

      r6_q     <= diff6[7:0];
      qe6_q    <= qe5_q;
      u6_q     <= u5_q;

      q7_q     <= q7_d;
      rr7_q    <= rr7_d;
      u7_q     <= u6_q;

      tens8_q  <= prod8a[14:11];
      t8_q     <= prod8b[17:11];
      rr8_q    <= rr7_q;
      q8_q     <= q7_q;
      u8_q     <= u7_q;

      units9_q <= units9_full[3:0];
      hu9_q    <= hu9_full[3:0];
      td9_q    <= prod9[14:11];
      tens9_q  <= tens8_q;
      t9_q     <= t8_q;
      u9_q     <= u8_q;

      flags_q  <= flags_d;
    end
  end

  assign out_o.valid                     = valid_q[LAST];
  assign out_o.is_gluon                  = flags_q.gluon;
  assign out_o.is_photon                 = flags_q.photon;
  assign out_o.is_zboson                 = flags_q.zboson;
  assign out_o.is_quark                  = flags_q.quark;
  assign out_o.is_diquark                = flags_q.diquark;
  assign out_o.is_light_quark_or_diquark = flags_q.light_qdq;
  assign out_o.is_charm_qdq              = flags_q.charm_qdq;
  assign out_o.is_bottom_qdq             = flags_q.bottom_qdq;
  assign out_o.is_charm_meson            = flags_q.charm_meson;
  assign out_o.is_bottom_meson           = flags_q.bottom_meson;
  assign out_o.is_neutral_pion           = flags_q.neutral_pion;

  // Remainder correction must land u below 100000
  `PCC_ASSERT_NOW(a_u_range, clk_i, rst_ni, valid_q[3], u4_q < pcc_pkg::UNEXC_MOD, "u out of range")
  // Corrected divide by 100
  `PCC_ASSERT_NOW(a_div100, clk_i, rst_ni, valid_q[6],
    (rr7_q < pcc_pkg::HUNDRED) && (q7_q < 10'd1000), "bad u/100 split")
  // Extracted digits are decimal
  `PCC_ASSERT_NOW(a_digits, clk_i, rst_ni, valid_q[8],
    (units9_q < pcc_pkg::TEN) && (hu9_q < pcc_pkg::TEN) && (tens9_q < pcc_pkg::TEN),
    "digit out of range")
  // A code cannot be both quark and diquark
  `PCC_ASSERT_NOW(a_q_dq_excl, clk_i, rst_ni, out_o.valid,
    !(out_o.is_quark && out_o.is_diquark), "quark and diquark both set")

endmodule

### dv/testbench.sv
// Testbench for particle_code_classifier: directed table plus random codes vs. a predictor.
module testbench;

  localparam int unsigned N_RANDOM     = 750;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 30;     // pipeline is 10 deep; leave margin
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;    // one long output stall
  localparam int unsigned HOLD_AFTER   = 150;    // results taken before that stall
  localparam int unsigned MAX_REPORTS  = 10;

  // One row of the directed table. When has_flags is clear the expected
  // flags come from the predictor instead of the row.
  typedef struct packed {
    logic signed [pcc_pkg::CODE_W-1:0] code;
    bit                                has_flags;
    pcc_pkg::pcc_flags_t               flags;
  } dir_row_t;

  localparam int unsigned N_DIR = 25;

  // Flag column order: gluon photon zboson _ quark diquark _ light charm bottom
  //                    _ charm_meson bottom_meson _ neutral_pion
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{ 32'sd21,          1'b1, 11'b100_00_000_00_0 },  // gluon
    '{ 32'sd9,           1'b1, 11'b100_00_000_00_0 },  // gluon, alternate code
    '{ 32'sd22,          1'b1, 11'b010_00_000_00_0 },  // photon
    '{ 32'sd23,          1'b1, 11'b001_00_000_00_0 },  // Z0
    '{ -32'sd21,         1'b1, 11'b000_00_000_00_0 },  // bosons never negative
    '{ 32'sd0,           1'b1, 11'b000_00_000_00_0 },
    '{ 32'sd1,           1'b1, 11'b000_10_100_00_0 },  // light quark
    '{ 32'sd4,           1'b1, 11'b000_10_010_00_0 },  // charm quark
    '{ 32'sd5,           1'b1, 11'b000_10_001_00_0 },  // bottom quark
    '{ 32'sd8,           1'b1, 11'b000_10_000_00_0 },  // top edge of quark range
    '{ -32'sd2,          1'b0, 11'b0 },                // antiquark
    '{ 32'sd1103,        1'b1, 11'b000_01_100_00_0 },  // lowest diquark
    '{ 32'sd2203,        1'b1, 11'b000_01_100_00_0 },
    '{ 32'sd4403,        1'b1, 11'b000_01_010_00_0 },
    '{ 32'sd5503,        1'b1, 11'b000_01_001_00_0 },
    '{ 32'sd8803,        1'b1, 11'b000_01_000_00_0 },  // highest diquark
    '{ 32'sd4503,        1'b0, 11'b0 },                // charm and bottom both
    '{ 32'sd1113,        1'b0, 11'b0 },                // tens digit set: no diquark
    '{ 32'sd111,         1'b1, 11'b000_00_000_00_1 },  // pi0
    '{ -32'sd111,        1'b1, 11'b000_00_000_00_1 },  // sign ignored
    '{ 32'sd411,         1'b1, 11'b000_00_000_10_0 },  // D+
    '{ 32'sd545,         1'b1, 11'b000_00_000_01_0 },  // B*c, top of tens range
    '{ 32'sd100001,      1'b0, 11'b0 },                // excited quark
    '{ 32'sd2147483647,  1'b0, 11'b0 },                // largest code
    '{ -32'sd2147483647, 1'b0, 11'b0 }                 // most negative legal code
  };

  // Field names indexed by bit position of pcc_flags_t
  localparam string FLAG_NAMES [11] = '{
    "is_neutral_pion", "is_bottom_meson", "is_charm_meson",
    "is_bottom_qdq", "is_charm_qdq",
    "is_light_quark_or_diquark", "is_diquark", "is_quark",
    "is_zboson", "is_photon", "is_gluon"
  };

  logic clk;
  logic rst_n;

  pcc_in_if  in_if ();
  pcc_out_if out_if ();

  particle_code_classifier i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Flags still owed by the block, oldest first
  pcc_pkg::pcc_flags_t pending_flags[$];
  int unsigned         mismatch_cnt;
  int unsigned         cycle_cnt;
  int unsigned         results_taken;
  bit                  send_burst;
  bit                  take_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: magnitude, unexcited code (mod 100000), low four digits for
  // the meson tests, then digit checks.
  // ---------------------------------------------------------------------------
  function automatic pcc_pkg::pcc_flags_t classify_code(
      input logic signed [pcc_pkg::CODE_W-1:0] code);
    logic [pcc_pkg::CODE_W-1:0] mag;
    int unsigned                unexc;
    int unsigned                low4;
    int unsigned                th;
    int unsigned                hu;
    int unsigned                m3, m2, m1, m0;
    bit                         diq;
    pcc_pkg::pcc_flags_t        f;
    mag   = code[pcc_pkg::CODE_W-1] ? -code : code;
    unexc = mag % pcc_pkg::UNEXC_MOD;
    low4  = mag % 10000;
    th    = unexc / 1000;
    hu    = (unexc % 1000) / 100;
    diq   = unexc >= pcc_pkg::DIQ_LO && unexc <= pcc_pkg::DIQ_HI &&
            ((unexc % 100) / 10) == 0;
    m3    = low4 / 1000;
    m2    = (low4 % 1000) / 100;
    m1    = (low4 % 100) / 10;
    m0    = low4 % 10;

    f.gluon        = code == pcc_pkg::GLUON_CODE || code == pcc_pkg::GLUON_ALT_CODE;
    f.photon       = code == pcc_pkg::PHOTON_CODE;
    f.zboson       = code == pcc_pkg::ZBOSON_CODE;
    f.quark        = unexc >= 1 && unexc <= 8;
    f.diquark      = diq;
    f.light_qdq    = (unexc >= 1 && unexc <= 3) ||
                     (diq && ((th >= 1 && th <= 3) || (hu >= 1 && hu <= 3)));
    f.charm_qdq    = unexc == 4 || (diq && (th == 4 || hu == 4));
    f.bottom_qdq   = unexc == 5 || (diq && (th == 5 || hu == 5));
    // mesons: thousands 0, odd spin digit 1/3/5; only hundreds and tens reach differ
    f.charm_meson  = m3 == 0 && m2 == 4 && m1 >= 1 && m1 <= 3 &&
                     (m0 == 1 || m0 == 3 || m0 == 5);
    f.bottom_meson = m3 == 0 && m2 == 5 && m1 >= 1 && m1 <= 4 &&
                     (m0 == 1 || m0 == 3 || m0 == 5);
    f.neutral_pion = unexc == pcc_pkg::PI0_CODE;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Random code source. Most draws are shaped to land near a class (quark,
  // diquark, meson, pi0, boson numbers), optionally lifted by a multiple of
  // the modulus so the excited digits get exercised; the rest are raw 32-bit
  // words and codes near the extremes. The most negative word is never sent.
  // ---------------------------------------------------------------------------
  function automatic logic signed [pcc_pkg::CODE_W-1:0] draw_code();
    int unsigned                       kind;
    int unsigned                       body;
    int unsigned                       scale;
    int unsigned                       mag;
    logic [pcc_pkg::CODE_W-1:0]        raw;
    logic signed [pcc_pkg::CODE_W-1:0] c;
    kind  = $urandom_range(0, 9);
    scale = 100000;
    body  = 0;
    case (kind)
      0: body = $urandom_range(0, 30);
      1: body = $urandom_range(0, 9);
      2, 3: begin
        body = $urandom_range(0, 9) * 1000 + $urandom_range(0, 9) * 100 +
               (($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) * 10 : 0) +
               $urandom_range(0, 9);
      end
      4, 5: begin
        scale = 10000;
        body  = (($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) * 1000 : 0) +
                $urandom_range(3, 6) * 100 + $urandom_range(0, 5) * 10 +
                $urandom_range(0, 9);
      end
      6: body = $urandom_range(100, 120);
      7, 8: begin
        raw = $urandom;
        if (raw == 32'h8000_0000) raw = 32'h8000_0001;
        return raw;
      end
      default: body = 32'h7fff_ffff - $urandom_range(0, 20);
    endcase

    mag = body;
    if (kind >= 1 && kind <= 6 && $urandom_range(0, 1) == 1) begin
      mag = body + $urandom_range(0, 32'h7fff_ffff / scale - 1) * scale;
    end
    c = mag;
    return ($urandom_range(0, 1) == 1) ? -c : c;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0d] MISMATCH: %s", cycle_cnt, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. valid stays high from one code to the next when no gap is
  // drawn; the expected flags are queued at the edge where the transaction
  // is taken.
  // ---------------------------------------------------------------------------
  task automatic send_code(input logic signed [pcc_pkg::CODE_W-1:0] code,
                           input pcc_pkg::pcc_flags_t flags);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.particle_code <= code;
    do @(posedge clk); while (!in_if.ready);
    pending_flags.push_back(flags);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random wait before each transaction, bursts with ready held
  // high, and one long stall so the pipeline fills and in_if.ready drops.
  // ---------------------------------------------------------------------------
  initial begin : take_results
    int unsigned stall;
    bit          held;
    out_if.ready <= 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 11);
      if (!held && results_taken >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      results_taken++;
    end
  end

  // Compare every output transaction with the oldest expected flags
  always @(posedge clk) begin : check_results
    pcc_pkg::pcc_flags_t got;
    pcc_pkg::pcc_flags_t want;
    string               diff;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.is_gluon, out_if.is_photon, out_if.is_zboson, out_if.is_quark,
             out_if.is_diquark, out_if.is_light_quark_or_diquark,
             out_if.is_charm_qdq, out_if.is_bottom_qdq,
             out_if.is_charm_meson, out_if.is_bottom_meson, out_if.is_neutral_pion};
      if (pending_flags.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected, flags %b", got));
      end else begin
        want = pending_flags.pop_front();
        if (got !== want) begin
          diff = "";
          for (int i = 10; i >= 0; i--) begin
            if (got[i] !== want[i]) diff = {diff, " ", FLAG_NAMES[i]};
          end
          log_mismatch($sformatf("expected %b got %b, fields:%s", want, got, diff));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("particle_code_classifier verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random codes, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic signed [pcc_pkg::CODE_W-1:0] code;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    results_taken = 0;
    send_burst    = 1'b0;
    take_burst    = 1'b0;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.particle_code <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      send_code(DIR_TAB[i].code,
                DIR_TAB[i].has_flags ? DIR_TAB[i].flags : classify_code(DIR_TAB[i].code));
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      code = draw_code();
      send_code(code, classify_code(code));
    end
    in_if.valid <= 1'b0;

    while (pending_flags.size() != 0) @(posedge clk);
    // Anything still coming out now is an extra result
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("particle_code_classifier verification clean");
    end else begin
      $display("particle_code_classifier verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pcc_pkg.sv
hdl/pcc_in_if.sv
hdl/pcc_out_if.sv
hdl/particle_code_classifier.sv
dv/testbench.sv
